### rtl/usg_pkg.sv
package usg_pkg;

    // Angle quotient bits: one full turn plus the carry bit for s == slice_count.
    localparam int QB = 33;
    // CORDIC datapath width, Q2.30 plus headroom.
    localparam int CW = 33;

    localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [31:0] ATAN [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    // Corner offsets, bit k = corner k
    localparam logic [5:0] MID_DS = 6'b101100;
    localparam logic [5:0] MID_DT = 6'b100110;
    localparam logic [5:0] BOT_DS = 6'b000100;
    localparam logic [5:0] BOT_DT = 6'b000010;

    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [2:0] corner;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
    } t_rot;

endpackage

### rtl/usg_in_if.sv
interface usg_in_if #(parameter int INDEX_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] slice_index;
    logic [INDEX_BITS-1:0] stack_index;

    modport source(output valid, output slice_index, output stack_index, input ready);
    modport sink(input valid, input slice_index, input stack_index, output ready);
endinterface

### rtl/usg_out_if.sv
interface usg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [2:0]         corner_number;
    logic               last_corner;
    logic               bad_cell;

    modport source(output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z,
                   output corner_number, output last_corner, output bad_cell,
                   input ready);
    modport sink(input valid, input pos_x, input pos_y, input pos_z,
                 input norm_x, input norm_y, input norm_z,
                 input corner_number, input last_corner, input bad_cell,
                 output ready);
endinterface

### rtl/usg_seq.sv
// Cell to corner sequencer: one corner per cycle while i_en is high, builds the angle dividends.
module usg_seq #(
    parameter int IB = 10,
    parameter int DW = IB + 33
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [IB-1:0]   i_slices,
    input  logic [IB-1:0]   i_stacks,
    input  logic            i_valid,
    input  logic [IB-1:0]   i_slice,
    input  logic [IB-1:0]   i_stack,
    output logic            o_ready,
    output usg_pkg::t_tag   o_tag,
    output logic [DW-1:0]   o_th,
    output logic [DW-1:0]   o_ph
);
    logic          r_busy;
    logic [IB-1:0] r_i;
    logic [IB-1:0] r_j;
    logic [2:0]    r_k;
    logic [2:0]    r_n;
    logic          r_bot;
    logic          r_bad;
    usg_pkg::t_tag r_tag;
    logic [DW-1:0] r_th;
    logic [DW-1:0] r_ph;

    logic          last_k;
    logic          accept;
    logic          in_bad;
    logic          ds;
    logic          dt;
    logic [IB:0]   s;
    logic [IB:0]   t;

    assign last_k  = (r_k == r_n - 3'd1);
    assign o_ready = i_en && (!r_busy || last_k);
    assign accept  = i_valid && o_ready;
    assign in_bad  = (i_slice >= i_slices) || (i_stack >= i_stacks);

    always_comb begin
        ds = r_bot ? usg_pkg::BOT_DS[r_k] : usg_pkg::MID_DS[r_k];
        dt = r_bot ? usg_pkg::BOT_DT[r_k] : usg_pkg::MID_DT[r_k];
        s  = {1'b0, r_i} + (IB+1)'(ds);
        t  = {1'b0, r_j} + (IB+1)'(dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tag  <= '0;
        end else if (i_en) begin
            if (accept) begin
                r_busy <= 1'b1;
                r_k    <= 3'd0;
                r_i    <= i_slice;
                r_j    <= i_stack;
                r_bad  <= in_bad;
                r_bot  <= (i_stack != '0) && (i_stack == i_stacks - IB'(1));
                if (in_bad)
                    r_n <= 3'd1;
                else if ((i_stack == '0) || (i_stack == i_stacks - IB'(1)))
                    r_n <= 3'd3;
                else
                    r_n <= 3'd6;
            end else if (r_busy && last_k) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_k <= r_k + 3'd1;
            end
            r_tag.valid  <= r_busy;
            r_tag.bad    <= r_bad;
            r_tag.corner <= r_bad ? 3'd0 : r_k;
            r_tag.last   <= last_k && !r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th <= {s, 32'd0} + DW'(i_slices >> 1);
            r_ph <= {1'b0, t, 31'd0} + DW'(i_stacks >> 1);
        end
    end

    assign o_tag = r_tag;
    assign o_th  = r_th;
    assign o_ph  = r_ph;
endmodule

### rtl/usg_div_cell.sv
// One restoring-division step for the theta and phi angle quotients.
module usg_div_cell #(
    parameter int IB = 10,
    parameter int DW = IB + 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [IB-1:0] i_div_th,
    input  logic [IB-1:0] i_div_ph,
    input  usg_pkg::t_tag i_tag,
    input  logic [DW-1:0] i_th,
    input  logic [DW-1:0] i_ph,
    output usg_pkg::t_tag o_tag,
    output logic [DW-1:0] o_th,
    output logic [DW-1:0] o_ph
);
    localparam int QB = usg_pkg::QB;

    usg_pkg::t_tag r_tag;
    logic [DW-1:0] r_th;
    logic [DW-1:0] r_ph;
    logic [DW-1:0] n_th;
    logic [DW-1:0] n_ph;
    logic [IB:0]   rem_th;
    logic [IB:0]   rem_ph;
    logic [IB:0]   dif_th;
    logic [IB:0]   dif_ph;

    always_comb begin
        rem_th = {i_th[DW-1:QB], i_th[QB-1]};
        rem_ph = {i_ph[DW-1:QB], i_ph[QB-1]};
        dif_th = rem_th - {1'b0, i_div_th};
        dif_ph = rem_ph - {1'b0, i_div_ph};
        if (rem_th >= {1'b0, i_div_th})
            n_th = {dif_th[IB-1:0], i_th[QB-2:0], 1'b1};
        else
            n_th = {rem_th[IB-1:0], i_th[QB-2:0], 1'b0};
        if (rem_ph >= {1'b0, i_div_ph})
            n_ph = {dif_ph[IB-1:0], i_ph[QB-2:0], 1'b1};
        else
            n_ph = {rem_ph[IB-1:0], i_ph[QB-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_tag <= '0;
        else if (i_en)
            r_tag <= i_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th <= n_th;
            r_ph <= n_ph;
        end
    end

    assign o_tag = r_tag;
    assign o_th  = r_th;
    assign o_ph  = r_ph;
endmodule

### rtl/usg_cordic_cell.sv
// One CORDIC rotation step for both angles.
module usg_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  usg_pkg::t_tag i_tag,
    input  usg_pkg::t_rot i_th,
    input  usg_pkg::t_rot i_ph,
    output usg_pkg::t_tag o_tag,
    output usg_pkg::t_rot o_th,
    output usg_pkg::t_rot o_ph
);
    localparam int CW = usg_pkg::CW;
    localparam logic signed [CW-1:0] ANG = $signed(CW'(usg_pkg::ATAN[STAGE]));

    usg_pkg::t_tag r_tag;
    usg_pkg::t_rot r_th;
    usg_pkg::t_rot r_ph;
    usg_pkg::t_rot n_th;
    usg_pkg::t_rot n_ph;

    always_comb begin
        n_th = i_th;
        n_ph = i_ph;
        if (!i_th.z[CW-1]) begin
            n_th.x = i_th.x - (i_th.y >>> STAGE);
            n_th.y = i_th.y + (i_th.x >>> STAGE);
            n_th.z = i_th.z - ANG;
        end else begin
            n_th.x = i_th.x + (i_th.y >>> STAGE);
            n_th.y = i_th.y - (i_th.x >>> STAGE);
            n_th.z = i_th.z + ANG;
        end
        if (!i_ph.z[CW-1]) begin
            n_ph.x = i_ph.x - (i_ph.y >>> STAGE);
            n_ph.y = i_ph.y + (i_ph.x >>> STAGE);
            n_ph.z = i_ph.z - ANG;
        end else begin
            n_ph.x = i_ph.x + (i_ph.y >>> STAGE);
            n_ph.y = i_ph.y - (i_ph.x >>> STAGE);
            n_ph.z = i_ph.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_tag <= '0;
        else if (i_en)
            r_tag <= i_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th <= n_th;
            r_ph <= n_ph;
        end
    end

    assign o_tag = r_tag;
    assign o_th  = r_th;
    assign o_ph  = r_ph;
endmodule

### rtl/usg_post.sv
// Quadrant fold, normal products, position scaling, rounding and saturation.
module usg_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [14:0]        i_radius,
    input  usg_pkg::t_tag      i_tag,
    input  usg_pkg::t_rot      i_th,
    input  usg_pkg::t_rot      i_ph,
    output usg_pkg::t_tag      o_tag,
    output logic signed [15:0] o_pos [0:2],
    output logic signed [15:0] o_norm [0:2]
);
    localparam int CW = usg_pkg::CW;

    usg_pkg::t_tag r1_tag, r2_tag, r3_tag, r4_tag, r5_tag, r6_tag;
    logic signed [CW-1:0]   r1_st, r1_ct, r1_sp, r1_cp;
    logic signed [2*CW-1:0] r2_pc, r2_ps;
    logic signed [CW-1:0]   r2_cp;
    logic signed [CW-1:0]   r3_n [0:2];
    logic signed [48:0]     r4_pr [0:2];
    logic signed [15:0]     r4_norm [0:2];
    logic signed [15:0]     r5_norm [0:2];
    logic signed [18:0]     r5_a [0:2];
    logic signed [15:0]     r6_pos [0:2];
    logic signed [15:0]     r6_norm [0:2];

    logic signed [CW-1:0]   st, ct, sp, cp;
    logic signed [2*CW-1:0] pc_rnd, ps_rnd;

    always_comb begin
        case (i_th.quad)
            2'd0:    begin ct = i_th.x;  st = i_th.y;  end
            2'd1:    begin ct = -i_th.y; st = i_th.x;  end
            2'd2:    begin ct = -i_th.x; st = -i_th.y; end
            default: begin ct = i_th.y;  st = -i_th.x; end
        endcase
        case (i_ph.quad)
            2'd0:    begin cp = i_ph.x;  sp = i_ph.y;  end
            2'd1:    begin cp = -i_ph.y; sp = i_ph.x;  end
            2'd2:    begin cp = -i_ph.x; sp = -i_ph.y; end
            default: begin cp = i_ph.y;  sp = -i_ph.x; end
        endcase
        pc_rnd = r2_pc + (2*CW)'(64'sd536870912);
        ps_rnd = r2_ps + (2*CW)'(64'sd536870912);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
            r5_tag <= '0;
            r6_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
            r5_tag <= r4_tag;
            r6_tag <= r5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_st <= st;
            r1_ct <= ct;
            r1_sp <= sp;
            r1_cp <= cp;
            r2_pc <= r1_sp * r1_ct;
            r2_ps <= r1_sp * r1_st;
            r2_cp <= r1_cp;
            r3_n[0] <= pc_rnd[CW+29:30];
            r3_n[1] <= ps_rnd[CW+29:30];
            r3_n[2] <= r2_cp;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [CW-1:0] n_rnd;
        logic signed [16:0]   nq;
        logic signed [48:0]   pr_off;
        logic signed [19:0]   a_off;
        logic [35:0]          prod;
        logic signed [17:0]   q;
        logic signed [17:0]   p;
        logic signed [15:0]   p_sat;

        always_comb begin
            n_rnd  = r3_n[k] + CW'(32768);
            nq     = n_rnd[CW-1:16];
            pr_off = r4_pr[k] + 49'sd1610612736;
            a_off  = 20'(r5_a[k]) + 20'sd196608;
            prod   = 36'(a_off[17:0]) * 36'd174763;
            q      = $signed({1'b0, prod[35:19]}) - 18'sd65536;
            p      = (k == 1) ? q + 18'sd8192 : q;
            if (p > 18'sd32767)
                p_sat = 16'sd32767;
            else if (p < -18'sd32768)
                p_sat = -16'sd32768;
            else
                p_sat = p[15:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r4_pr[k] <= $signed({1'b0, i_radius}) * r3_n[k];
                if (nq > 17'sd16384)
                    r4_norm[k] <= 16'sd16384;
                else if (nq < -17'sd16384)
                    r4_norm[k] <= -16'sd16384;
                else
                    r4_norm[k] <= nq[15:0];
                r5_a[k]    <= pr_off[48:30];
                r5_norm[k] <= r4_norm[k];
                r6_pos[k]  <= r5_tag.bad ? 16'sd0 : p_sat;
                r6_norm[k] <= r5_tag.bad ? 16'sd0 : r5_norm[k];
            end
        end

        assign o_pos[k]  = r6_pos[k];
        assign o_norm[k] = r6_norm[k];
    end

    assign o_tag = r6_tag;
endmodule

### rtl/uv_sphere_triangle_generator_top.sv
// UV sphere triangle generator. Each input item is one grid cell (slice_index,
// stack_index); the block returns the de-indexed triangle corners of that cell:
// 3 for the top and bottom rows, 6 for the rows between, or a single item with
// bad_cell set when the cell lies outside the configured grid. Corners leave at
// one per cycle while the output is taken, and the next cell is taken in the
// cycle its last corner enters the pipeline. Every corner goes through a chain
// of 33 restoring-division cells (theta = slice*turn/slice_count, phi =
// stack*half turn/stack_count), CORDIC_STAGES CORDIC cells (sine and cosine of
// both angles) and 6 post stages. The whole chain stalls together when the
// output item is not taken, so results are never dropped. radius, slice_count
// and stack_count (indexes 0, 1, 2) are to be written only while the block is
// idle; the block does not enforce this. A write to index 3 is ignored.
module uv_sphere_triangle_generator_top #(
    parameter int INDEX_BITS    = 10,
    parameter int CORDIC_STAGES = 16,
    localparam int CFG_W        = (INDEX_BITS > 15) ? INDEX_BITS : 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    usg_in_if.sink           i_in,
    usg_out_if.source        o_out
);
    localparam int IB = INDEX_BITS;
    localparam int QB = usg_pkg::QB;
    localparam int DW = IB + QB;

    // Configuration registers
    logic [14:0]   r_radius;
    logic [IB-1:0] r_slices;
    logic [IB-1:0] r_stacks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 15'd4096;
            r_slices <= IB'(32);
            r_stacks <= IB'(16);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                usg_pkg::REG_RADIUS: r_radius <= i_cfg_data[14:0];
                usg_pkg::REG_SLICES: r_slices <= i_cfg_data[IB-1:0];
                usg_pkg::REG_STACKS: r_stacks <= i_cfg_data[IB-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the output register is empty or being drained.
    logic en;
    usg_pkg::t_tag out_tag;
    assign en = !out_tag.valid || o_out.ready;

    // Sequencer emits one corner per cycle while en is high.
    usg_pkg::t_tag tag_d [0:QB];
    logic [DW-1:0] th_d  [0:QB];
    logic [DW-1:0] ph_d  [0:QB];

    usg_seq #(.IB(IB), .DW(DW)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_slices (r_slices),
        .i_stacks (r_stacks),
        .i_valid  (i_in.valid),
        .i_slice  (i_in.slice_index),
        .i_stack  (i_in.stack_index),
        .o_ready  (i_in.ready),
        .o_tag    (tag_d[0]),
        .o_th     (th_d[0]),
        .o_ph     (ph_d[0])
    );

    // Divider chain: one quotient bit per cell, theta and phi side by side.
    for (genvar g = 0; g < QB; g++) begin : g_div
        usg_div_cell #(.IB(IB), .DW(DW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_div_th (r_slices),
            .i_div_ph (r_stacks),
            .i_tag    (tag_d[g]),
            .i_th     (th_d[g]),
            .i_ph     (ph_d[g]),
            .o_tag    (tag_d[g+1]),
            .o_th     (th_d[g+1]),
            .o_ph     (ph_d[g+1])
        );
    end

    // Binary angle (mod one turn) -> quadrant plus first-quadrant residue.
    usg_pkg::t_tag tag_c [0:CORDIC_STAGES];
    usg_pkg::t_rot th_c  [0:CORDIC_STAGES];
    usg_pkg::t_rot ph_c  [0:CORDIC_STAGES];

    always_comb begin
        tag_c[0]     = tag_d[QB];
        th_c[0].x    = usg_pkg::CORDIC_GAIN;
        th_c[0].y    = '0;
        th_c[0].z    = $signed(usg_pkg::CW'(th_d[QB][29:0]));
        th_c[0].quad = th_d[QB][31:30];
        ph_c[0].x    = usg_pkg::CORDIC_GAIN;
        ph_c[0].y    = '0;
        ph_c[0].z    = $signed(usg_pkg::CW'(ph_d[QB][29:0]));
        ph_c[0].quad = ph_d[QB][31:30];
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        usg_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (tag_c[g]),
            .i_th    (th_c[g]),
            .i_ph    (ph_c[g]),
            .o_tag   (tag_c[g+1]),
            .o_th    (th_c[g+1]),
            .o_ph    (ph_c[g+1])
        );
    end

    // Normals and positions; the last post stage is the output register.
    logic signed [15:0] pos  [0:2];
    logic signed [15:0] norm [0:2];

    usg_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_radius (r_radius),
        .i_tag    (tag_c[CORDIC_STAGES]),
        .i_th     (th_c[CORDIC_STAGES]),
        .i_ph     (ph_c[CORDIC_STAGES]),
        .o_tag    (out_tag),
        .o_pos    (pos),
        .o_norm   (norm)
    );

    assign o_out.valid         = out_tag.valid;
    assign o_out.pos_x         = pos[0];
    assign o_out.pos_y         = pos[1];
    assign o_out.pos_z         = pos[2];
    assign o_out.norm_x        = norm[0];
    assign o_out.norm_y        = norm[1];
    assign o_out.norm_z        = norm[2];
    assign o_out.corner_number = out_tag.corner;
    assign o_out.last_corner   = out_tag.last;
    assign o_out.bad_cell      = out_tag.bad;
endmodule

### tb/sv/uv_sphere_triangle_generator_top_test.sv
module uv_sphere_triangle_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDX_W       = 10;
    localparam int  STAGES      = 16;
    localparam int  CFG_W       = 15;
    // Pipeline depth is 40 + STAGES; give it generous room when draining.
    localparam int  DRAIN       = 120;
    localparam longint LIMIT    = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [2:0]         corner_number;
        logic               last_corner;
        logic               bad_cell;
    } t_corner;

    // Directed cell: known_bad rows carry a typed-in expectation.
    typedef struct {
        logic [IDX_W-1:0] slice;
        logic [IDX_W-1:0] stack;
        bit               known_bad;
    } t_cell_row;

    typedef struct {
        logic [CFG_W-1:0] radius;
        logic [IDX_W-1:0] slices;
        logic [IDX_W-1:0] stacks;
        int               cells;
        bit               steady;
        bit               write_regs;
    } t_grid_setup;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    usg_in_if #(.INDEX_BITS(IDX_W)) in_if();
    usg_out_if                      out_if();

    uv_sphere_triangle_generator_top #(
        .INDEX_BITS    (IDX_W),
        .CORDIC_STAGES (STAGES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow copy of the grid registers
    longint  sh_radius;
    longint  sh_slices;
    longint  sh_stacks;

    t_corner corner_q[$];
    int      n_errors;
    longint  n_cycles;
    bit      steady;     // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    // Sine and cosine (Q2.30) of a 32-bit binary angle.
    function automatic void cordic_sincos(input logic [31:0] ang,
                                          output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(ang[29:0]);
        for (int k = 0; k < STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(usg_pkg::ATAN[k]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(usg_pkg::ATAN[k]);
            end
        end
        case (ang[31:30])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // radius * n / 3, rounded to nearest (half up), n in Q30
    function automatic longint scale_third(input longint n30);
        longint d, num;
        d   = longint'(3) <<< 30;
        num = sh_radius * n30 + d / 2;
        if (num >= 0)
            return num / d;
        return -((-num + d - 1) / d);
    endfunction

    function automatic t_corner grid_corner(input longint s, input longint t);
        t_corner     c;
        logic [31:0] theta, phi;
        longint      st, ct, sp, cp;
        longint      nv[3];
        longint      p, q;
        theta = 32'(((s <<< 32) + sh_slices / 2) / sh_slices);
        phi   = 32'(((t <<< 31) + sh_stacks / 2) / sh_stacks);
        cordic_sincos(theta, st, ct);
        cordic_sincos(phi, sp, cp);
        nv[0] = rnd_shift(sp * ct, 30);
        nv[1] = rnd_shift(sp * st, 30);
        nv[2] = cp;
        c = '0;
        for (int k = 0; k < 3; k++) begin
            p = clamp(scale_third(nv[k]) + ((k == 1) ? 8192 : 0), -32768, 32767);
            q = clamp(rnd_shift(nv[k], 16), -16384, 16384);
            case (k)
                0: begin c.pos_x = 16'(p); c.norm_x = 16'(q); end
                1: begin c.pos_y = 16'(p); c.norm_y = 16'(q); end
                default: begin c.pos_z = 16'(p); c.norm_z = 16'(q); end
            endcase
        end
        return c;
    endfunction

    // Queue up every corner that one accepted cell produces.
    function automatic void predict_cell(input logic [IDX_W-1:0] si,
                                         input logic [IDX_W-1:0] ti);
        longint  i, j;
        int      n;
        int      ds[6], dt[6];
        t_corner c;
        i = longint'(si);
        j = longint'(ti);
        if (i >= sh_slices || j >= sh_stacks) begin
            c = '0;
            c.bad_cell = 1'b1;
            corner_q = {corner_q, c};
            return;
        end
        if (j == 0) begin
            // top row: fan from the pole, stack 0 -> 1
            ds = '{0, 0, 1, 0, 0, 0};
            dt = '{0, 1, 1, 0, 0, 0};
            n  = 3;
        end else if (j == sh_stacks - 1) begin
            ds = '{0, 0, 1, 0, 0, 0};
            dt = '{0, 1, 0, 0, 0, 0};
            n  = 3;
        end else begin
            ds = '{0, 0, 1, 1, 0, 1};
            dt = '{0, 1, 1, 0, 0, 1};
            n  = 6;
        end
        for (int k = 0; k < n; k++) begin
            c = grid_corner(i + ds[k], j + dt[k]);
            c.corner_number = 3'(k);
            c.last_corner   = (k == n - 1);
            c.bad_cell      = 1'b0;
            corner_q = {corner_q, c};
        end
    endfunction

    // ---------------- result side ----------------

    // Sink ready: random stalls, changed only at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
    end

    // Handshake signals settle between edges, so sample at the falling edge;
    // an item seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_corner got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.pos_x         = out_if.pos_x;
            got.pos_y         = out_if.pos_y;
            got.pos_z         = out_if.pos_z;
            got.norm_x        = out_if.norm_x;
            got.norm_y        = out_if.norm_y;
            got.norm_z        = out_if.norm_z;
            got.corner_number = out_if.corner_number;
            got.last_corner   = out_if.last_corner;
            got.bad_cell      = out_if.bad_cell;
            if (corner_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected corner item %p", $time, got);
            end else begin
                want = corner_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    $display("%0t: corner mismatch expected %p actual %p",
                             $time, want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic write_reg(input logic [1:0] idx, input longint val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
    endtask

    // Offer one cell; optional random idle first. Returns once accepted.
    task automatic send_cell(input logic [IDX_W-1:0] si, input logic [IDX_W-1:0] ti,
                             input bit known_bad);
        t_corner c;
        if (!steady && $urandom_range(99) < 14) begin
            @(posedge i_clk);
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4)) @(posedge i_clk);
        end
        @(posedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.slice_index <= si;
        in_if.stack_index <= ti;
        do
            @(negedge i_clk);
        while (!in_if.ready);
        if (known_bad) begin
            c = '0;
            c.bad_cell = 1'b1;
            corner_q = {corner_q, c};
        end else begin
            predict_cell(si, ti);
        end
    endtask

    // Mostly well-formed cells, weighted toward the special rows; some raw noise.
    task automatic send_random_cell();
        logic [IDX_W-1:0] si, ti;
        int pick;
        pick = $urandom_range(99);
        if (sh_slices == 0 || sh_stacks == 0 || pick < 12) begin
            si = IDX_W'($urandom);
            ti = IDX_W'($urandom);
        end else begin
            si = IDX_W'($urandom_range(32'(sh_slices - 1)));
            if (pick < 30)
                ti = '0;
            else if (pick < 48)
                ti = IDX_W'(sh_stacks - 1);
            else
                ti = IDX_W'($urandom_range(32'(sh_stacks - 1)));
        end
        send_cell(si, ti, 1'b0);
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        in_if.valid <= 1'b0;
        while (corner_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    t_cell_row   cell_rows[] = '{
        '{10'd0,    10'd0,    1'b0},   // top row, first slice
        '{10'd31,   10'd0,    1'b0},   // top row, wraps to slice_count
        '{10'd0,    10'd15,   1'b0},   // bottom row
        '{10'd31,   10'd15,   1'b0},   // bottom row, last slice
        '{10'd5,    10'd7,    1'b0},   // middle row, six corners
        '{10'd31,   10'd14,   1'b0},
        '{10'd16,   10'd8,    1'b0},   // equator
        '{10'd8,    10'd1,    1'b0},
        '{10'd32,   10'd0,    1'b1},   // slice just past the grid
        '{10'd0,    10'd16,   1'b1},   // stack just past the grid
        '{10'd1023, 10'd1023, 1'b1},   // all ones
        '{10'd1023, 10'd3,    1'b1},
        '{10'd2,    10'd1023, 1'b1},
        '{10'd24,   10'd12,   1'b0}
    };

    t_grid_setup setups[] = '{
        '{15'd4096,  10'd32,   10'd16,   60, 1'b0, 1'b0},  // reset values
        '{15'd0,     10'd3,    10'd2,    30, 1'b0, 1'b1},  // zero radius, smallest grid
        '{15'd32767, 10'd1023, 10'd1023, 60, 1'b1, 1'b1},  // largest everything
        '{15'd12345, 10'd7,    10'd1,    20, 1'b0, 1'b1},  // single stack row
        '{15'd4096,  10'd0,    10'd5,    10, 1'b0, 1'b1},  // zero slices: all bad
        '{15'd0,     10'd0,    10'd0,    70, 1'b0, 1'b1},  // randomized below
        '{15'd20000, 10'd64,   10'd3,    60, 1'b0, 1'b1}
    };

    initial begin
        t_grid_setup g;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = usg_pkg::REG_RADIUS;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.slice_index = '0;
        in_if.stack_index = '0;
        out_if.ready      = 1'b0;
        n_errors          = 0;
        n_cycles          = 0;
        steady            = 1'b0;
        sh_radius         = 4096;
        sh_slices         = 32;
        sh_stacks         = 16;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (setups[p]) begin
            g = setups[p];
            if (p == 5) begin
                g.radius = CFG_W'($urandom_range(32767));
                g.slices = IDX_W'($urandom_range(3, 1023));
                g.stacks = IDX_W'($urandom_range(2, 1023));
            end
            if (g.write_regs) begin
                drain_results();
                // index 3 is not a register; the write must change nothing
                write_reg(REG_UNUSED, $urandom);
                write_reg(usg_pkg::REG_RADIUS, g.radius);
                write_reg(usg_pkg::REG_SLICES, g.slices);
                write_reg(usg_pkg::REG_STACKS, g.stacks);
                @(posedge i_clk);
                i_cfg_wr_en <= 1'b0;
                sh_radius = g.radius;
                sh_slices = g.slices;
                sh_stacks = g.stacks;
            end
            steady = g.steady;
            if (p == 0) begin
                foreach (cell_rows[r])
                    send_cell(cell_rows[r].slice, cell_rows[r].stack,
                              cell_rows[r].known_bad);
            end
            repeat (g.cells) send_random_cell();
        end

        steady = 1'b0;
        drain_results();
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
